FILE: hdl/jhw_pkg.sv
// Shared types, constants and helpers for the JPEG header walker.
`default_nettype none
package jhw_pkg;

    localparam int MAX_FRAME_BYTES = 1048576;
    localparam int MAX_SEG_LEN     = 65536;

    localparam int DATA_W = 8;
    localparam int CFG_W  = 21;
    localparam int HDR_W  = 21;
    localparam int PAY_W  = 21;
    localparam int DIM_W  = 8;

    localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int HE_W   = $clog2(MAX_FRAME_BYTES + MAX_SEG_LEN);
    localparam int CMP_W  = (POS_W > CFG_W) ? POS_W : CFG_W;
    localparam int SEG_W  = 4;

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = CFG_W'(1048576);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_MAX_PAYLOAD = '0;

    localparam logic [7:0] MARK_FF   = 8'hFF;
    localparam logic [7:0] MARK_SOI  = 8'hD8;
    localparam logic [7:0] MARK_APP0 = 8'hE0;
    localparam logic [7:0] MARK_SOF0 = 8'hC0;

    localparam logic [SEG_W-1:0] SEG_IDLE   = SEG_W'(0);
    localparam logic [SEG_W-1:0] SEG_ARMED  = SEG_W'(1);
    localparam logic [SEG_W-1:0] SEG_HGT_HI = SEG_W'(5);
    localparam logic [SEG_W-1:0] SEG_HGT_LO = SEG_W'(6);
    localparam logic [SEG_W-1:0] SEG_WID_HI = SEG_W'(7);
    localparam logic [SEG_W-1:0] SEG_WID_LO = SEG_W'(8);

    typedef enum logic [3:0] {
        PH_START,
        PH_APP_HI,
        PH_APP_LO,
        PH_SKIP,
        PH_MARK2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DONE,
        PH_BAD
    } t_phase;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } t_byte_req;

    typedef struct packed {
        logic [HDR_W-1:0] header_bytes;
        logic [PAY_W-1:0] payload_bytes;
        logic [DIM_W-1:0] width_units;
        logic [DIM_W-1:0] height_units;
        logic             start_ok;
        logic             truncated;
        logic             overrun;
    } t_result;

    typedef struct packed {
        t_phase           phase;
        logic [HE_W-1:0]  header_end;
        logic [POS_W-1:0] frame_len;
        logic [DIM_W-1:0] width_units;
        logic [DIM_W-1:0] height_units;
    } t_snap;

    function automatic logic [7:0] start_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = MARK_FF;
            2'd1: b = MARK_SOI;
            2'd2: b = MARK_FF;
            2'd3: b = MARK_APP0;
            default: b = MARK_FF;
        endcase
        return b;
    endfunction

    function automatic logic [DIM_W-1:0] dim_units(input logic [7:0] hi, input logic [7:0] lo);
        return {hi[2:0], lo[7:3]};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/jhw_parse.sv
// Per-byte marker walk state and end-of-frame snapshot register.
`default_nettype none
module jhw_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire jhw_pkg::t_byte_req i_req,
    output logic                   o_snap_valid,
    output jhw_pkg::t_snap         o_snap
);
    import jhw_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [SEG_W-1:0] r_seg, n_seg;
    logic [7:0]       r_dim_hi, n_dim_hi;
    logic [DIM_W-1:0] r_width, n_width;
    logic [DIM_W-1:0] r_height, n_height;
    logic [HE_W-1:0]  r_he, n_he;
    logic             r_snap_valid, n_snap_valid;
    t_snap            r_snap, n_snap;
    logic [7:0]       b;

    assign b = i_req.data_byte;

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_len_hi     = r_len_hi;
        n_seg        = r_seg;
        n_dim_hi     = r_dim_hi;
        n_width      = r_width;
        n_height     = r_height;
        n_he         = r_he;
        n_snap_valid = 1'b0;
        n_snap       = r_snap;
        if (i_valid) begin
            if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
                if (r_seg != SEG_IDLE) begin
                    n_seg = r_seg + SEG_W'(1);
                    if (n_seg == SEG_HGT_HI || n_seg == SEG_WID_HI) begin
                        n_dim_hi = b;
                    end else if (n_seg == SEG_HGT_LO) begin
                        n_height = dim_units(r_dim_hi, b);
                    end else if (n_seg == SEG_WID_LO) begin
                        n_width = dim_units(r_dim_hi, b);
                        n_seg   = SEG_IDLE;
                    end
                end
                case (r_phase)
                    PH_START: begin
                        if (b != start_byte(r_pos[1:0])) begin
                            n_phase = PH_BAD;
                        end else if (r_pos == POS_W'(3)) begin
                            n_phase = PH_APP_HI;
                        end
                    end
                    PH_APP_HI, PH_LEN_HI: begin
                        n_len_hi = b;
                        n_phase  = (r_phase == PH_APP_HI) ? PH_APP_LO : PH_LEN_LO;
                    end
                    PH_APP_LO, PH_LEN_LO: begin
                        n_he = HE_W'(r_pos) + HE_W'({r_len_hi, b}) - HE_W'(1);
                        if (r_len_hi == 8'h00 && b < 8'd2) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (HE_W'(r_pos) == r_he) begin
                            n_phase = (b != MARK_FF) ? PH_DONE : PH_MARK2;
                        end
                    end
                    PH_MARK2: begin
                        if (b == MARK_SOF0) begin
                            n_seg = SEG_ARMED;
                        end
                        n_phase = PH_LEN_HI;
                    end
                    default: begin
                    end
                endcase
                n_pos = r_pos + POS_W'(1);
            end
            if (i_req.last_byte) begin
                n_snap_valid        = 1'b1;
                n_snap.phase        = n_phase;
                n_snap.header_end   = n_he;
                n_snap.frame_len    = n_pos;
                n_snap.width_units  = n_width;
                n_snap.height_units = n_height;
                n_pos    = '0;
                n_phase  = PH_START;
                n_len_hi = '0;
                n_seg    = SEG_IDLE;
                n_dim_hi = '0;
                n_he     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= PH_START;
            r_len_hi     <= '0;
            r_seg        <= SEG_IDLE;
            r_dim_hi     <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_he         <= '0;
            r_snap_valid <= 1'b0;
        end else if (i_en) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_len_hi     <= n_len_hi;
            r_seg        <= n_seg;
            r_dim_hi     <= n_dim_hi;
            r_width      <= n_width;
            r_height     <= n_height;
            r_he         <= n_he;
            r_snap_valid <= n_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule
`default_nettype wire

FILE: hdl/jhw_finish.sv
// Header and payload length resolution and result register.
`default_nettype none
module jhw_finish (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_snap_valid,
    input  wire jhw_pkg::t_snap             i_snap,
    input  wire logic [jhw_pkg::CFG_W-1:0]  i_max_payload,
    output logic                            o_valid,
    output jhw_pkg::t_result                o_res
);
    import jhw_pkg::*;

    logic             r_valid;
    t_result          r_res, n_res;
    logic [POS_W-1:0] header;
    logic [CMP_W-1:0] payload;
    logic [CMP_W-1:0] max_ext;
    logic             ok, over;

    always_comb begin
        ok     = 1'b1;
        over   = 1'b0;
        header = i_snap.frame_len;
        case (i_snap.phase)
            PH_START, PH_BAD: begin
                ok     = 1'b0;
                header = '0;
            end
            PH_DONE: begin
                if (i_snap.header_end <= HE_W'(i_snap.frame_len)) begin
                    header = POS_W'(i_snap.header_end);
                end
            end
            PH_SKIP: begin
                if (i_snap.header_end > HE_W'(i_snap.frame_len)) begin
                    over = 1'b1;
                end else begin
                    header = POS_W'(i_snap.header_end);
                end
            end
            default: begin
                over = 1'b1;
            end
        endcase
        payload = CMP_W'(i_snap.frame_len - header);
        max_ext = CMP_W'(i_max_payload);
        n_res.truncated = 1'b0;
        if (payload > max_ext) begin
            payload         = max_ext;
            n_res.truncated = 1'b1;
        end
        n_res.header_bytes  = HDR_W'(header);
        n_res.payload_bytes = PAY_W'(payload);
        n_res.width_units   = i_snap.width_units;
        n_res.height_units  = i_snap.height_units;
        n_res.start_ok      = ok;
        n_res.overrun       = over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

FILE: hdl/jpeg_header_walker.sv
// Top level of the JPEG header walker: input register, config port, parse and finish stages.
//
//  channel   direction  handshake                    payload
//  byte      in         i_byte_valid / o_byte_ready  i_byte  (t_byte_req)
//  result    out        o_res_valid / i_res_ready    o_res   (t_result)
//  config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One byte is accepted per cycle unless the stages hold; a result appears once the last byte
// of a frame has passed the input register, then parse and snapshot, then the result register.
// All three stages advance together and hold while the result register is full and
// not taken; o_byte_ready is low only then.
// Synchronous active-low reset clears the walk state, dimensions and valid bits and
// sets max_payload to 1048576.
`default_nettype none
module jpeg_header_walker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_byte_valid,
    output logic                              o_byte_ready,
    input  wire jhw_pkg::t_byte_req           i_byte,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output jhw_pkg::t_result                  o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jhw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [jhw_pkg::APB_DW-1:0]   pwdata,
    output logic [jhw_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import jhw_pkg::*;

    logic             en;
    logic             r_in_valid;
    t_byte_req        r_in;
    logic [CFG_W-1:0] r_max_payload;
    logic             snap_valid;
    t_snap            snap;
    logic             res_valid;
    logic             reg_hit;

    assign en           = !res_valid || i_res_ready;
    assign o_byte_ready = en;
    assign o_res_valid  = res_valid;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_MAX_PAYLOAD);
    assign prdata  = reg_hit ? APB_DW'(r_max_payload) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_payload <= pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_byte_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_byte;
        end
    end

    jhw_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (r_in_valid),
        .i_req        (r_in),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    jhw_finish u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_snap_valid  (snap_valid),
        .i_snap        (snap),
        .i_max_payload (r_max_payload),
        .o_valid       (res_valid),
        .o_res         (o_res)
    );

endmodule
`default_nettype wire
